// ----- hw/rtl/dsh_pkg.sv -----
// Shared types, codes and helpers for the diamond-square heightmap unit.
// No dependencies.
package dsh_pkg;

  localparam int HEIGHT_W = 24;

  localparam logic OP_GENERATE = 1'b0;
  localparam logic OP_READ     = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_DONE  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  localparam logic [1:0] REG_AMPLITUDE   = 2'd0;
  localparam logic [1:0] REG_PERSISTENCE = 2'd1;
  localparam logic [1:0] REG_SEED        = 2'd2;

  typedef logic signed [HEIGHT_W-1:0] height_t;

  function automatic logic [31:0] xs_next(input logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

// ----- hw/rtl/dsh_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module dsh_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1089
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/diamond_square_heightmap_unit.sv -----
// Diamond-square heightmap unit: generate and read commands over one height RAM.
// Depends on dsh_pkg and dsh_ram.
//
// channel | dir | fields
// s_axis  | in  | tuser: operation; tdata: col, row
// m_axis  | out | tdata: height; tuser: status
// cfg     | in  | we, addr, wdata (amplitude, persistence, seed)
//
// Read: one RAM read, then the result; an out-of-range read skips the RAM.
// Generate: the four corners are written first, then each cell takes four RAM
// reads through the single read port, a noise multiply and a write back.
// rst is synchronous; the height RAM is not cleared.
// A new word is taken while the last result still waits on m_tready.
module diamond_square_heightmap_unit #(
  parameter int SIDE_LOG2 = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [5:0] col, [11:6] row
  input  logic        s_tuser,   // [0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [23:0] height
  output logic [1:0]  m_tuser,   // [1:0] status
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam int SIDE  = (1 << SIDE_LOG2) + 1;
  localparam int CELLS = SIDE * SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = SIDE_LOG2 + 1;
  localparam int HW    = dsh_pkg::HEIGHT_W;
  localparam logic [CW-1:0] LAST = CW'(SIDE - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_CORN = 3'd2;
  localparam logic [2:0] ST_SQ   = 3'd3;
  localparam logic [2:0] ST_DM   = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]  state;
  logic [2:0]  k;
  logic [1:0]  corner;
  logic [CW-1:0] off;
  logic [CW-1:0] c;
  logic [CW-1:0] r;
  logic        rowodd;

  logic [19:0] amplitude;
  logic [15:0] persistence;
  logic [31:0] seed;
  logic [31:0] noise_state;
  logic [23:0] noise_range;

  logic signed [16:0] u_reg;
  logic signed [41:0] prod;
  logic signed [25:0] noise;
  logic signed [25:0] acc;
  dsh_pkg::height_t pend_h;
  logic [1:0]  pend_s;

  logic          we;
  logic [AW-1:0] waddr;
  logic [HW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [HW-1:0] rdata;

  logic [5:0]  in_col;
  logic [5:0]  in_row;
  logic        in_range;
  logic        accept;
  logic        out_free;
  logic [31:0] x_new;
  logic signed [16:0] u_new;
  logic [CW-1:0] nc;
  logic [CW-1:0] nr;
  logic [CW:0] c2;
  logic [CW:0] r2;
  logic [CW:0] r1;
  logic signed [25:0] mean;
  logic signed [26:0] total;
  dsh_pkg::height_t sat;
  logic [CW-1:0] corner_c;
  logic [CW-1:0] corner_r;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] cc,
                                              input logic [CW-1:0] rr);
    return (AW'(rr) << SIDE_LOG2) + AW'(rr) + AW'(cc);
  endfunction

  dsh_ram #(.WIDTH(HW), .DEPTH(CELLS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign in_col   = s_tdata[5:0];
  assign in_row   = s_tdata[11:6];
  assign in_range = (32'(in_col) < 32'(SIDE)) && (32'(in_row) < 32'(SIDE));
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign x_new = dsh_pkg::xs_next(noise_state);
  assign u_new = $signed({~x_new[31], x_new[30:15]});

  always_comb begin
    nc = c;
    nr = r;
    if (state == ST_SQ) begin
      case (k[1:0])
        2'd0: begin nc = c - off; nr = r - off; end
        2'd1: begin nc = c + off; nr = r - off; end
        2'd2: begin nc = c + off; nr = r + off; end
        default: begin nc = c - off; nr = r + off; end
      endcase
    end else begin
      case (k[1:0])
        2'd0: nc = (c == '0) ? LAST - off : c - off;
        2'd1: nc = (c == LAST) ? off : c + off;
        2'd2: nr = (r == '0) ? LAST - off : r - off;
        default: nr = (r == LAST) ? off : r + off;
      endcase
    end
  end

  assign raddr = (state == ST_IDLE) ? cell_addr(CW'(in_col), CW'(in_row)) : cell_addr(nc, nr);

  assign mean  = acc >>> 2;
  assign total = 27'(mean) + 27'(noise);
  always_comb begin
    if (total > 27'sd8388607) begin
      sat = 24'sh7FFFFF;
    end else if (total < -27'sd8388608) begin
      sat = 24'sh800000;
    end else begin
      sat = HW'(total);
    end
  end

  assign corner_c = corner[1] ? LAST : '0;
  assign corner_r = corner[0] ? LAST : '0;

  always_comb begin
    we    = 1'b0;
    waddr = cell_addr(c, r);
    wdata = sat;
    if (state == ST_CORN) begin
      we    = 1'b1;
      waddr = cell_addr(corner_c, corner_r);
      wdata = HW'(u_new);
    end else if ((state == ST_SQ || state == ST_DM) && k == 3'd5) begin
      we = 1'b1;
    end
  end

  assign c2 = {1'b0, c} + ({1'b0, off} << 1);
  assign r2 = {1'b0, r} + ({1'b0, off} << 1);
  assign r1 = {1'b0, r} + {1'b0, off};

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude   <= 20'd65536;
      persistence <= 16'd32768;
      seed        <= 32'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        dsh_pkg::REG_AMPLITUDE:   amplitude   <= cfg_wdata[19:0];
        dsh_pkg::REG_PERSISTENCE: persistence <= cfg_wdata[15:0];
        dsh_pkg::REG_SEED:        seed        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (k)
      3'd0: u_reg <= u_new;
      3'd1: begin
        prod <= u_reg * $signed({1'b0, noise_range});
        acc  <= 26'($signed(rdata));
      end
      3'd2: begin
        noise <= 26'(prod >>> 16);
        acc   <= acc + 26'($signed(rdata));
      end
      3'd3: acc <= acc + 26'($signed(rdata));
      3'd4: acc <= acc + 26'($signed(rdata));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      k           <= '0;
      corner      <= '0;
      off         <= '0;
      c           <= '0;
      r           <= '0;
      rowodd      <= 1'b0;
      noise_state <= 32'd1;
      noise_range <= '0;
      m_tvalid    <= 1'b0;
      m_tdata     <= '0;
      m_tuser     <= '0;
      pend_h      <= '0;
      pend_s      <= '0;
    end else begin
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_tuser == dsh_pkg::OP_GENERATE) begin
              noise_state <= (seed == '0) ? 32'd1 : seed;
              noise_range <= 24'(amplitude);
              off         <= CW'(1) << (SIDE_LOG2 - 1);
              corner      <= '0;
              state       <= ST_CORN;
            end else if (in_range) begin
              state <= ST_READ;
            end else begin
              pend_h <= '0;
              pend_s <= dsh_pkg::STATUS_RANGE;
              state  <= ST_OUT;
            end
          end
        end
        ST_READ: begin
          pend_h <= rdata;
          pend_s <= dsh_pkg::STATUS_OK;
          state  <= ST_OUT;
        end
        ST_CORN: begin
          noise_state <= x_new;
          corner      <= corner + 2'd1;
          if (corner == 2'd3) begin
            c     <= off;
            r     <= off;
            k     <= '0;
            state <= ST_SQ;
          end
        end
        ST_SQ, ST_DM: begin
          if (k == 3'd0) begin
            noise_state <= x_new;
          end
          if (k != 3'd5) begin
            k <= k + 3'd1;
          end else begin
            k <= '0;
            if (c2 <= {1'b0, LAST}) begin
              c <= c2[CW-1:0];
            end else if (state == ST_SQ) begin
              if (r2 <= {1'b0, LAST}) begin
                r <= r2[CW-1:0];
                c <= off;
              end else begin
                r      <= '0;
                c      <= off;
                rowodd <= 1'b0;
                state  <= ST_DM;
              end
            end else if (r1 <= {1'b0, LAST}) begin
              r      <= r1[CW-1:0];
              rowodd <= ~rowodd;
              c      <= rowodd ? off : '0;
            end else begin
              noise_range <= 24'((40'(noise_range) * 40'(persistence)) >> 16);
              off <= off >> 1;
              if (off == CW'(1)) begin
                pend_h <= '0;
                pend_s <= dsh_pkg::STATUS_DONE;
                state  <= ST_OUT;
              end else begin
                c     <= off >> 1;
                r     <= off >> 1;
                state <= ST_SQ;
              end
            end
          end
        end
        ST_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= pend_h;
            m_tuser  <= pend_s;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/diamond_square_heightmap_unit_tb.sv -----
`timescale 1ns / 100ps
// Testbench for diamond_square_heightmap_unit: generate and read words checked
// against an in-bench diamond-square predictor. Depends on dsh_pkg.
module diamond_square_heightmap_unit_tb;

  localparam int LOG2 = 5;
  localparam int SIDE = (1 << LOG2) + 1;
  localparam int LAST = SIDE - 1;
  localparam int IDLE_PCT = 28;

  typedef struct packed {
    logic       op;
    logic [5:0] col;
    logic [5:0] row;
  } cmd_t;

  typedef struct packed {
    logic [23:0] height;
    logic [1:0]  status;
  } answer_t;

  logic        clk, rst;
  logic        s_tvalid, s_tready, s_tuser;
  logic [15:0] s_tdata;
  logic        m_tvalid, m_tready;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [31:0] cfg_wdata;

  diamond_square_heightmap_unit #(.SIDE_LOG2(LOG2)) DUT (.*);

  cmd_t    cmd_q[$];
  answer_t answer_q[$];
  int      errors, n_results, n_gen, n_read, n_range;
  bit      quiet_mode, driver_hold;

  logic [19:0]        amp_r;
  logic [15:0]        pers_r;
  logic [31:0]        seed_r;
  logic [31:0]        rng;
  longint             range_q16;
  logic signed [23:0] hmap[SIDE*SIDE];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint floor_div(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint draw_noise_unit();
    rng = rng ^ (rng << 13);
    rng = rng ^ (rng >> 17);
    rng = rng ^ (rng << 5);
    return longint'(rng >> 15) - 65536;
  endfunction

  function automatic void place_cell(int c, int r, longint sum4);
    longint nz, v;
    nz = floor_div(draw_noise_unit() * range_q16, 16);
    v = floor_div(sum4, 2) + nz;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    hmap[r*SIDE + c] = v[23:0];
  endfunction

  function automatic longint hm(int c, int r);
    return longint'(hmap[r*SIDE + c]);
  endfunction

  function automatic void build_heightmap();
    int off;
    bit oddr, oddc;
    longint s;
    off = LAST / 2;
    rng = (seed_r == 0) ? 32'd1 : seed_r;
    range_q16 = amp_r;
    hmap[0] = 24'(draw_noise_unit());
    hmap[LAST*SIDE] = 24'(draw_noise_unit());
    hmap[LAST] = 24'(draw_noise_unit());
    hmap[LAST*SIDE + LAST] = 24'(draw_noise_unit());
    while (off > 0) begin
      for (int r = off; r <= LAST; r += 2*off)
        for (int c = off; c <= LAST; c += 2*off)
          place_cell(c, r, hm(c-off, r-off) + hm(c+off, r-off) +
                           hm(c+off, r+off) + hm(c-off, r+off));
      oddr = 0;
      for (int r = 0; r <= LAST; r += off) begin
        oddc = 0;
        for (int c = 0; c <= LAST; c += off) begin
          if (oddc != oddr) begin
            s = hm(c == 0 ? LAST-off : c-off, r) + hm(c == LAST ? off : c+off, r)
              + hm(c, r == 0 ? LAST-off : r-off) + hm(c, r == LAST ? off : r+off);
            place_cell(c, r, s);
          end
          oddc = ~oddc;
        end
        oddr = ~oddr;
      end
      range_q16 = ((range_q16 * pers_r) >> 16) & 24'hFFFFFF;
      off /= 2;
    end
  endfunction

  function automatic answer_t predict_answer(cmd_t c);
    answer_t a;
    if (c.op == dsh_pkg::OP_GENERATE) begin
      build_heightmap();
      a = '{24'd0, dsh_pkg::STATUS_DONE};
    end else if (c.col >= SIDE || c.row >= SIDE) begin
      a = '{24'd0, dsh_pkg::STATUS_RANGE};
    end else begin
      a = '{hmap[c.row*SIDE + c.col], dsh_pkg::STATUS_OK};
    end
    return a;
  endfunction

  // driver
  cmd_t cur;
  bit   sent;
  always @(posedge clk) sent <= s_tvalid && s_tready;

  always @(negedge clk) begin
    if (!rst && (!s_tvalid || sent)) begin
      if (!driver_hold && cmd_q.size() > 0 &&
          (quiet_mode || $urandom_range(99) >= IDLE_PCT)) begin
        cur = cmd_q[0];
        s_tuser <= cur.op;
        s_tdata <= {4'd0, cur.row, cur.col};
        s_tvalid <= 1;
      end else begin
        s_tvalid <= 0;
      end
    end
    m_tready <= rst ? 1'b0 : (quiet_mode || $urandom_range(99) >= IDLE_PCT);
  end

  // monitor: prediction happens at acceptance so register state is current
  always @(posedge clk) begin
    answer_t e;
    if (!rst && s_tvalid && s_tready) begin
      answer_q.push_back(predict_answer(cmd_q[0]));
      void'(cmd_q.pop_front());
    end
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (answer_q.size() == 0) begin
        $error("unexpected word: height %h status %0d", m_tdata, m_tuser);
        errors++;
      end else begin
        e = answer_q.pop_front();
        if (m_tdata !== e.height) begin
          $error("height: expected %h actual %h", e.height, m_tdata);
          errors++;
        end
        if (m_tuser !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, m_tuser);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= v;
    case (idx)
      dsh_pkg::REG_AMPLITUDE:   amp_r = v[19:0];
      dsh_pkg::REG_PERSISTENCE: pers_r = v[15:0];
      dsh_pkg::REG_SEED:        seed_r = v;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    while (cmd_q.size() > 0 || answer_q.size() > 0 || s_tvalid) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic push(logic op, int c, int r);
    cmd_t k;
    k = '{op, 6'(c), 6'(r)};
    cmd_q.push_back(k);
    if (op == dsh_pkg::OP_GENERATE) n_gen++;
    else if (k.col >= SIDE || k.row >= SIDE) n_range++;
    else n_read++;
  endtask

  task automatic push_read_valid();
    push(dsh_pkg::OP_READ, $urandom_range(LAST), $urandom_range(LAST));
  endtask

  initial begin
    int k;
    rst = 1; s_tvalid = 0; s_tuser = 0; s_tdata = 0; m_tready = 0;
    cfg_we = 0; cfg_addr = 0; cfg_wdata = 0;
    amp_r = 20'd65536; pers_r = 16'd32768; seed_r = 1;
    repeat (12) @(posedge clk);
    @(negedge clk) rst = 0;

    // directed: reset registers, corners, edges, out of range
    push(dsh_pkg::OP_GENERATE, 0, 0);
    push(dsh_pkg::OP_READ, 0, 0); push(dsh_pkg::OP_READ, LAST, 0);
    push(dsh_pkg::OP_READ, 0, LAST); push(dsh_pkg::OP_READ, LAST, LAST);
    push(dsh_pkg::OP_READ, 16, 16); push(dsh_pkg::OP_READ, SIDE, 0);
    push(dsh_pkg::OP_READ, 0, SIDE); push(dsh_pkg::OP_READ, 63, 63);
    push(dsh_pkg::OP_READ, 42, 21); push(dsh_pkg::OP_READ, 21, 42);
    drain();
    write_reg(dsh_pkg::REG_AMPLITUDE, 32'hFFFFF);
    write_reg(dsh_pkg::REG_PERSISTENCE, 32'hFFFF);
    write_reg(dsh_pkg::REG_SEED, 32'd0);
    push(dsh_pkg::OP_GENERATE, 63, 63);
    push(dsh_pkg::OP_READ, 0, 0); push(dsh_pkg::OP_READ, LAST, LAST);
    push(dsh_pkg::OP_READ, 1, 1); push(dsh_pkg::OP_READ, 31, 30);
    drain();
    write_reg(dsh_pkg::REG_AMPLITUDE, 0);
    write_reg(dsh_pkg::REG_PERSISTENCE, 0);
    write_reg(dsh_pkg::REG_SEED, 32'hFFFFFFFF);
    push(dsh_pkg::OP_GENERATE, 0, 0);
    push(dsh_pkg::OP_READ, 8, 24); push(dsh_pkg::OP_READ, 32, 32);
    drain();

    // random phases with fresh register values
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(dsh_pkg::REG_AMPLITUDE, $urandom_range(20'hFFFFF));
      write_reg(dsh_pkg::REG_PERSISTENCE, $urandom_range(16'hFFFF));
      write_reg(dsh_pkg::REG_SEED, $urandom());
      quiet_mode = (ph == 2);
      push(dsh_pkg::OP_GENERATE, $urandom(), $urandom());
      for (k = 0; k < 28; k++) begin
        if ($urandom_range(9) == 0) push(dsh_pkg::OP_READ, $urandom(), $urandom());
        else if ($urandom_range(29) == 0)
          push(dsh_pkg::OP_GENERATE, $urandom(), $urandom());
        else push_read_valid();
        if (ph == 1 && k == 14) begin
          // sender waits for everything outstanding
          driver_hold = 1;
          @(negedge clk);
          while (answer_q.size() > 0 || s_tvalid) @(negedge clk);
          driver_hold = 0;
        end
      end
      drain();
    end
    quiet_mode = 0;

    $display("covered %0d generates, %0d in-range reads, %0d out-of-range reads",
             n_gen, n_read, n_range);
    $display("%0d result words checked across several register settings", n_results);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end
endmodule
